[rtl/core/tle_pkg.sv]
// shared types, constants and decode function for the terminal line editor
package tle_pkg;

  // line storage geometry
  localparam int unsigned LineCap = 64;
  localparam int unsigned AddrW   = $clog2(LineCap);
  localparam int unsigned CountW  = 7;
  localparam int unsigned LimitW  = 7;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned ActW    = 3;

  // field packing on the result stream
  localparam int unsigned OutDataW = 24;

  // line limit after reset
  localparam logic [LimitW-1:0] LimitReset = LimitW'(40);

  // special keyboard bytes
  localparam logic [ByteW-1:0] CodeEof   = 8'd4;
  localparam logic [ByteW-1:0] CodeKill  = 8'd21;
  localparam logic [ByteW-1:0] CodeWord  = 8'd23;
  localparam logic [ByteW-1:0] CodeErase = 8'd127;
  localparam logic [ByteW-1:0] CharSpace = 8'd32;
  localparam logic [ByteW-1:0] CharTilde = 8'd126;

  // result actions
  typedef enum logic [ActW-1:0] {
    ACT_ECHO  = 3'd0,
    ACT_ERASE = 3'd1,
    ACT_WRAP  = 3'd2,
    ACT_BELL  = 3'd3,
    ACT_END   = 3'd4
  } action_e;

  // decoded request kind
  typedef enum logic [2:0] {
    OP_END,
    OP_ERASE1,
    OP_KILL,
    OP_WORD,
    OP_PRINT,
    OP_BELL
  } op_e;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK_SPACE,
    ST_WALK_WORD,
    ST_DONE
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic do_op;
    logic walk_dec;
    logic walk_load;
  } tle_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_word;
    logic cnt_zero;
    logic char_space;
  } tle_status_t;

  // classify one received byte
  function automatic op_e classify(logic [ByteW-1:0] b, logic line_empty);
    op_e op;
    if (b == CodeEof && line_empty) begin
      op = OP_END;
    end else if (b == CodeErase) begin
      op = OP_ERASE1;
    end else if (b == CodeKill) begin
      op = OP_KILL;
    end else if (b == CodeWord) begin
      op = OP_WORD;
    end else if (b >= CharSpace && b <= CharTilde) begin
      op = OP_PRINT;
    end else begin
      op = OP_BELL;
    end
    return op;
  endfunction

endpackage

[rtl/core/terminal_line_editor.sv]
// top level of the terminal line editor: stream ports, controller and datapath
// One request is one keyboard byte and gives one result. Printable bytes, erase,
// line kill, end of input and bell are handled straight from the idle state. Word
// erase walks back through the line store over its single read port, one character
// per cycle, first over spaces and then over the word, before its result is loaded.
// A new byte is taken in the idle state as soon as the result register is free or
// is being emptied in the same cycle, and not while a word erase runs. Line limit
// writes are taken at any time; the limit is clamped to 1..64 when used.
module terminal_line_editor (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // line limit configuration
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [tle_pkg::LimitW-1:0]     cfg_data_i,
  // keyboard byte requests
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [tle_pkg::ByteW-1:0]      s_axis_tdata_i,   // [7:0] in_byte
  // editor results
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [tle_pkg::OutDataW-1:0]   m_axis_tdata_o,   // [7:0] echo_char,
                                                           // [14:8] erase_count,
                                                           // [21:15] line_length,
                                                           // [23:22] zero
  output logic [tle_pkg::ActW-1:0]       m_axis_tuser_o    // [2:0] action
);
  import tle_pkg::*;

  tle_cmd_t          cmd;
  tle_status_t       status;
  logic [ByteW-1:0]  echo_char;
  logic [CountW-1:0] erase_count;
  logic [CountW-1:0] line_length;

  assign cfg_ready_o = 1'b1;

  // sequencing
  tle_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // line storage and result
  tle_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_byte_i     (s_axis_tdata_i),
    .cfg_we_i      (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .action_o      (m_axis_tuser_o),
    .echo_char_o   (echo_char),
    .erase_count_o (erase_count),
    .line_length_o (line_length)
  );

  // result packing
  assign m_axis_tdata_o = {2'b00, line_length, erase_count, echo_char};

endmodule

[rtl/core/tle_ctrl.sv]
// controller state machine: request intake and the backward word walk
module tle_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  tle_pkg::tle_status_t status_i,
  output tle_pkg::tle_cmd_t    cmd_o
);
  import tle_pkg::*;

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i && status_i.out_free && status_i.is_word) begin
          state_d = ST_WALK_SPACE;
        end
      end
      ST_WALK_SPACE: begin
        if (status_i.cnt_zero) begin
          state_d = ST_DONE;
        end else if (!status_i.char_space) begin
          state_d = ST_WALK_WORD;
        end
      end
      ST_WALK_WORD: begin
        if (status_i.cnt_zero || status_i.char_space) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status_i.out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready_o      = 1'b0;
    cmd_o.do_op     = 1'b0;
    cmd_o.walk_dec  = 1'b0;
    cmd_o.walk_load = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = status_i.out_free;
        cmd_o.do_op = in_valid_i && status_i.out_free;
      end
      ST_WALK_SPACE: begin
        cmd_o.walk_dec = !status_i.cnt_zero && status_i.char_space;
      end
      ST_WALK_WORD: begin
        cmd_o.walk_dec = !status_i.cnt_zero && !status_i.char_space;
      end
      ST_DONE: begin
        cmd_o.walk_load = status_i.out_free;
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

endmodule

[rtl/core/tle_datapath.sv]
// datapath: line store, length and erase counters, limit and result register
module tle_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [tle_pkg::ByteW-1:0]    in_byte_i,
  input  logic                         cfg_we_i,
  input  logic [tle_pkg::LimitW-1:0]   cfg_data_i,
  input  tle_pkg::tle_cmd_t            cmd_i,
  output tle_pkg::tle_status_t         status_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [tle_pkg::ActW-1:0]     action_o,
  output logic [tle_pkg::ByteW-1:0]    echo_char_o,
  output logic [tle_pkg::CountW-1:0]   erase_count_o,
  output logic [tle_pkg::CountW-1:0]   line_length_o
);
  import tle_pkg::*;

  logic [ByteW-1:0]  line_mem [LineCap];
  logic [ByteW-1:0]  rdata_q;
  logic [AddrW-1:0]  raddr;
  logic              mem_we;
  logic [AddrW-1:0]  waddr;

  logic [CountW-1:0] cnt_q, cnt_d;
  logic [CountW-1:0] erased_q, erased_d;
  logic [LimitW-1:0] lim_q;
  logic [CountW-1:0] lim_eff;
  op_e               op;

  logic              out_valid_q, out_valid_d;
  logic              out_load;
  action_e           act_q, act_d;
  logic [ByteW-1:0]  echo_q, echo_d;
  logic [CountW-1:0] erase_out_q, erase_out_d;
  logic [CountW-1:0] len_q;

  // decode and status
  assign op                  = classify(in_byte_i, cnt_q == '0);
  assign status_o.out_free   = !out_valid_q || out_ready_i;
  assign status_o.is_word    = (op == OP_WORD);
  assign status_o.cnt_zero   = (cnt_q == '0);
  assign status_o.char_space = (rdata_q == CharSpace);

  // clamp the limit to 1..capacity
  always_comb begin
    if (lim_q == '0) begin
      lim_eff = CountW'(1);
    end else if (CountW'(lim_q) > CountW'(LineCap)) begin
      lim_eff = CountW'(LineCap);
    end else begin
      lim_eff = CountW'(lim_q);
    end
  end

  // per request update of length, store and result
  always_comb begin
    cnt_d       = cnt_q;
    erased_d    = erased_q;
    mem_we      = 1'b0;
    waddr       = cnt_q[AddrW-1:0];
    act_d       = ACT_BELL;
    echo_d      = '0;
    erase_out_d = '0;
    out_load    = 1'b0;
    if (cmd_i.do_op) begin
      out_load = (op != OP_WORD);
      unique case (op)
        OP_END: begin
          act_d = ACT_END;
        end
        OP_ERASE1: begin
          act_d = ACT_ERASE;
          if (cnt_q != '0) begin
            cnt_d       = cnt_q - CountW'(1);
            erase_out_d = CountW'(1);
          end
        end
        OP_KILL: begin
          act_d       = ACT_ERASE;
          erase_out_d = cnt_q;
          cnt_d       = '0;
        end
        OP_WORD: begin
          erased_d = '0;
        end
        OP_PRINT: begin
          echo_d = in_byte_i;
          mem_we = 1'b1;
          if (cnt_q < lim_eff) begin
            act_d = ACT_ECHO;
            cnt_d = cnt_q + CountW'(1);
          end else begin
            act_d = ACT_WRAP;
            waddr = '0;
            cnt_d = CountW'(1);
          end
        end
        OP_BELL: begin
          act_d = ACT_BELL;
        end
        default: begin
          act_d = ACT_BELL;
        end
      endcase
    end else if (cmd_i.walk_dec) begin
      cnt_d    = cnt_q - CountW'(1);
      erased_d = erased_q + CountW'(1);
    end else if (cmd_i.walk_load) begin
      out_load    = 1'b1;
      act_d       = ACT_ERASE;
      erase_out_d = erased_q;
    end
  end

  // always prefetch the last character of the next line state
  assign raddr = AddrW'(cnt_d - CountW'(1));

  // line store
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      line_mem[waddr] <= in_byte_i;
    end
    rdata_q <= line_mem[raddr];
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      lim_q       <= LimitReset;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        lim_q <= cfg_data_i;
      end
    end
  end

  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // erase tally and result payload
  always_ff @(posedge clk_i) begin
    erased_q <= erased_d;
    if (out_load) begin
      act_q       <= act_d;
      echo_q      <= echo_d;
      erase_out_q <= erase_out_d;
      len_q       <= cnt_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign action_o      = act_q;
  assign echo_char_o   = echo_q;
  assign erase_count_o = erase_out_q;
  assign line_length_o = len_q;

endmodule

[rtl/core/tle_checker.sv]
// port level checks for the terminal line editor and their binding
module tle_checker (
  input logic                         clk_i,
  input logic                         rst_ni,
  input logic                         s_axis_tready_o,
  input logic                         m_axis_tvalid_o,
  input logic                         m_axis_tready_i,
  input logic [tle_pkg::OutDataW-1:0] m_axis_tdata_o,
  input logic [tle_pkg::ActW-1:0]     m_axis_tuser_o
);
  import tle_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
    else $error("result changed while stalled");

  // a new request is only taken when the result register can drain
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o && m_axis_tvalid_o |-> m_axis_tready_i)
    else $error("request taken while result register full");

  // echo and wrap carry a printable byte, no erase, and a non-empty line
  a_echo_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == ACT_ECHO || m_axis_tuser_o == ACT_WRAP) |->
      m_axis_tdata_o[7:0] >= CharSpace && m_axis_tdata_o[7:0] <= CharTilde &&
      m_axis_tdata_o[14:8] == '0 && m_axis_tdata_o[21:15] != '0)
    else $error("bad echo result");

  // end of input only on an empty line, with no echo and no erase
  a_end_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tuser_o == ACT_END |->
      m_axis_tdata_o[21:0] == '0)
    else $error("bad end of input result");

endmodule

bind terminal_line_editor tle_checker u_tle_checker (.*);
